/* design/rdc_pkg.sv */
// Shared constants, types and helpers for the radix digit converter.
package rdc_pkg;

  localparam int unsigned VALUE_BITS_DEF = 64;
  localparam int unsigned BASE_BITS      = 5;
  localparam int unsigned CHAR_BITS      = 8;
  localparam int unsigned CFG_IDX_BITS   = 1;

  localparam logic [BASE_BITS-1:0] BASE_RESET = 5'd10;

  // configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_INPUT_BASE  = 1'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_OUTPUT_BASE = 1'd1;

  localparam logic [CHAR_BITS-1:0] CHAR_ZERO = 8'd48;  // '0'
  localparam logic [CHAR_BITS-1:0] CHAR_A    = 8'd65;  // 'A'
  localparam logic [CHAR_BITS-1:0] TEN       = 8'd10;

  // status from the accumulator to the sequencer and emitter
  typedef struct packed {
    logic done;
    logic ovf;
  } acc_stat_t;

  // radix 0 and 1 behave as 2
  function automatic logic [BASE_BITS-1:0] eff_base(input logic [BASE_BITS-1:0] b);
    eff_base = (b < 5'd2) ? 5'd2 : b;
  endfunction

  // digit value to ASCII; letters carry on past 'F'
  function automatic logic [CHAR_BITS-1:0] digit_to_char(input logic [BASE_BITS-1:0] r);
    logic [CHAR_BITS-1:0] r8;
    r8 = {3'd0, r};
    digit_to_char = (r8 >= TEN) ? (r8 - TEN + CHAR_A) : (r8 + CHAR_ZERO);
  endfunction

endpackage

/* design/rdc_accum.sv */
// Bit-serial multiply-accumulate of one digit into the running value.
module rdc_accum #(
  parameter int unsigned VALUE_BITS = rdc_pkg::VALUE_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           load,
  input  logic [rdc_pkg::CHAR_BITS-1:0]  digit_char,
  input  logic [rdc_pkg::BASE_BITS-1:0]  base,
  input  logic                           clear,
  output logic [VALUE_BITS-1:0]          value,
  output rdc_pkg::acc_stat_t             stat
);

  localparam int unsigned CNT_W = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(VALUE_BITS - 1);

  logic [VALUE_BITS-1:0] acc, pw;
  logic [rdc_pkg::CHAR_BITS-1:0] mag;
  logic                  neg;
  logic [rdc_pkg::CHAR_BITS-1:0] pcar;   // product carry, stays below mag
  logic [rdc_pkg::BASE_BITS-1:0] wcar;   // weight carry, stays below base
  logic                  cy;             // add carry / subtract borrow
  logic [CNT_W-1:0]      cnt;
  logic                  run;
  logic                  ovf, wover, done;

  logic [rdc_pkg::CHAR_BITS:0]   psum;
  logic [rdc_pkg::BASE_BITS:0]   wsum;
  logic                          tbit, abit, rbit, cy_next;
  logic [rdc_pkg::CHAR_BITS-1:0] pcar_next;
  logic [rdc_pkg::BASE_BITS-1:0] wcar_next;
  logic [rdc_pkg::CHAR_BITS-1:0] mag_next;
  logic                          neg_next;

  always_comb begin
    psum      = {1'b0, pcar} + (pw[0] ? {1'b0, mag} : '0);
    tbit      = psum[0];
    pcar_next = psum[rdc_pkg::CHAR_BITS:1];
    wsum      = {1'b0, wcar} + (pw[0] ? {1'b0, base} : '0);
    wcar_next = wsum[rdc_pkg::BASE_BITS:1];
    abit      = acc[0];
    rbit      = abit ^ tbit ^ cy;
    if (neg) begin
      cy_next = (~abit & tbit) | (~abit & cy) | (tbit & cy);
    end else begin
      cy_next = (abit & tbit) | (abit & cy) | (tbit & cy);
    end
  end

  // digit magnitude and sign from the character
  always_comb begin
    neg_next = 1'b0;
    if (digit_char >= rdc_pkg::CHAR_A) begin
      mag_next = digit_char - rdc_pkg::CHAR_A + rdc_pkg::TEN;
    end else if (digit_char >= rdc_pkg::CHAR_ZERO) begin
      mag_next = digit_char - rdc_pkg::CHAR_ZERO;
    end else begin
      mag_next = rdc_pkg::CHAR_ZERO - digit_char;
      neg_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc   <= '0;
      pw    <= VALUE_BITS'(1);
      ovf   <= 1'b0;
      wover <= 1'b0;
      run   <= 1'b0;
      done  <= 1'b0;
      cnt   <= '0;
    end else begin
      done <= run && !clear && !load && (cnt == CNT_LAST);
      if (clear) begin
        acc   <= '0;
        pw    <= VALUE_BITS'(1);
        ovf   <= 1'b0;
        wover <= 1'b0;
      end else if (load) begin
        mag  <= mag_next;
        neg  <= neg_next;
        pcar <= '0;
        wcar <= '0;
        cy   <= 1'b0;
        cnt  <= '0;
        run  <= 1'b1;
      end else if (run) begin
        acc  <= {rbit, acc[VALUE_BITS-1:1]};
        pw   <= {wsum[0], pw[VALUE_BITS-1:1]};
        pcar <= pcar_next;
        wcar <= wcar_next;
        cy   <= cy_next;
        cnt  <= cnt + 1'b1;
        if (cnt == CNT_LAST) begin
          run  <= 1'b0;
          // product past range, or add carry / subtract borrow out
          if (((mag != '0) && (wover || (pcar_next != '0))) || cy_next) begin
            ovf <= 1'b1;
          end
          if (wcar_next != '0) begin
            wover <= 1'b1;
          end
        end
      end
    end
  end

  assign value     = acc;
  assign stat.done = done;
  assign stat.ovf  = ovf;

endmodule

/* design/rdc_divider.sv */
// Bit-serial restoring divider that emits output digits, least significant first.
module rdc_divider #(
  parameter int unsigned VALUE_BITS = rdc_pkg::VALUE_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           load,
  input  logic [VALUE_BITS-1:0]          value,
  input  logic                           ovf_in,
  input  logic [rdc_pkg::BASE_BITS-1:0]  base,
  output logic                           out_valid,
  output logic [rdc_pkg::CHAR_BITS-1:0]  out_char,
  output logic                           out_last,
  output logic                           overflow
);

  localparam int unsigned CNT_W = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(VALUE_BITS - 1);

  logic [VALUE_BITS-1:0]         v;
  logic [rdc_pkg::BASE_BITS-1:0] rem;
  logic                          qnz;   // any quotient bit set so far
  logic                          ovf;
  logic [CNT_W-1:0]              cnt;
  logic                          run;

  logic [rdc_pkg::BASE_BITS:0]   trial;
  logic                          ge;
  logic [rdc_pkg::BASE_BITS-1:0] rem_next;
  logic [rdc_pkg::BASE_BITS:0]   trial_sub;

  always_comb begin
    trial     = {rem, v[VALUE_BITS-1]};
    ge        = trial >= {1'b0, base};
    trial_sub = trial - {1'b0, base};
    rem_next  = ge ? trial_sub[rdc_pkg::BASE_BITS-1:0] : trial[rdc_pkg::BASE_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run       <= 1'b0;
      out_valid <= 1'b0;
      cnt       <= '0;
    end else begin
      out_valid <= run && !load && (cnt == CNT_LAST);
      if (load) begin
        v   <= value;
        ovf <= ovf_in;
        rem <= '0;
        qnz <= 1'b0;
        cnt <= '0;
        run <= 1'b1;
      end else if (run) begin
        v <= {v[VALUE_BITS-2:0], ge};
        if (cnt == CNT_LAST) begin
          out_char <= rdc_pkg::digit_to_char(rem_next);
          out_last <= ~(qnz | ge);
          overflow <= ovf;
          // quotient is already in v; next division starts straight away
          rem <= '0;
          qnz <= 1'b0;
          cnt <= '0;
          run <= qnz | ge;
        end else begin
          rem <= rem_next;
          qnz <= qnz | ge;
          cnt <= cnt + 1'b1;
        end
      end
    end
  end

endmodule

/* design/radix_digit_converter.sv */
// Top level of the radix digit converter: config registers, sequencer, datapath.
//
// Usage: digit characters arrive least significant first. A transfer happens
// at a clock edge with start high and busy low; final_digit marks the most
// significant character of a number. Each character is folded into the
// running value by a bit-serial multiply-accumulate, one value bit a cycle,
// and busy stays high until the character has been folded in.
// After the final character the value is divided by the output radix, bit
// serially; digits leave least significant first, each on out_char for one
// cycle with out_valid high, out_last on the last one and overflow on all
// of them, and busy stays high until the last one has left. The receiver
// cannot stall: every strobe is a transfer. After emission the running
// value, weight and overflow flag return to their reset state for the next
// number.
// Reset (synchronous, rst high) sets both radix registers to ten and clears
// the value. Radix registers are written through cfg_write / cfg_index /
// cfg_data; the user must write them only while busy is low, as the block
// itself does not enforce it. A radix of 0 or 1 acts as 2.
module radix_digit_converter #(
  parameter int unsigned VALUE_BITS = rdc_pkg::VALUE_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [rdc_pkg::CHAR_BITS-1:0]     digit_char,
  input  logic                              final_digit,
  input  logic                              cfg_write,
  input  logic [rdc_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [rdc_pkg::BASE_BITS-1:0]     cfg_data,
  output logic                              out_valid,
  output logic [rdc_pkg::CHAR_BITS-1:0]     out_char,
  output logic                              out_last,
  output logic                              overflow
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_ACC  = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0] state, state_next;
  logic [rdc_pkg::BASE_BITS-1:0] input_base, output_base;
  logic fin;                       // latched final_digit of the current transfer

  logic                   accept, acc_clear, div_load;
  logic [VALUE_BITS-1:0]  acc_value;
  rdc_pkg::acc_stat_t     acc_stat;

  assign accept = start && !busy;
  assign busy   = (state != ST_IDLE);

  // radix registers
  always_ff @(posedge clk) begin
    if (rst) begin
      input_base  <= rdc_pkg::BASE_RESET;
      output_base <= rdc_pkg::BASE_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        rdc_pkg::REG_INPUT_BASE:  input_base  <= cfg_data;
        rdc_pkg::REG_OUTPUT_BASE: output_base <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer: accumulate, then emit if this was the final digit
  always_comb begin
    state_next = state;
    acc_clear  = 1'b0;
    div_load   = 1'b0;
    case (state)
      ST_IDLE: begin
        if (accept) state_next = ST_ACC;
      end
      ST_ACC: begin
        if (acc_stat.done) begin
          if (fin) begin
            div_load   = 1'b1;
            state_next = ST_EMIT;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      ST_EMIT: begin
        if (out_valid && out_last) begin
          acc_clear  = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      fin   <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) fin <= final_digit;
    end
  end

  rdc_accum #(.VALUE_BITS(VALUE_BITS)) u_accum (
    .clk        (clk),
    .rst        (rst),
    .load       (accept),
    .digit_char (digit_char),
    .base       (rdc_pkg::eff_base(input_base)),
    .clear      (acc_clear),
    .value      (acc_value),
    .stat       (acc_stat)
  );

  rdc_divider #(.VALUE_BITS(VALUE_BITS)) u_divider (
    .clk       (clk),
    .rst       (rst),
    .load      (div_load),
    .value     (acc_value),
    .ovf_in    (acc_stat.ovf),
    .base      (rdc_pkg::eff_base(output_base)),
    .out_valid (out_valid),
    .out_char  (out_char),
    .out_last  (out_last),
    .overflow  (overflow)
  );

  // digits only leave while a number is being emitted
  a_valid_in_emit: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (state == ST_EMIT))
    else $error("output strobe outside emission");

  // digits are spaced by a whole division
  a_valid_spaced: assert property (@(posedge clk) disable iff (rst)
    out_valid |=> !out_valid)
    else $error("back-to-back output strobes");

  // a transfer always starts an accumulation
  a_accept_acc: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == ST_ACC))
    else $error("accepted digit not accumulated");

  // accumulation only finishes while the sequencer waits for it
  a_done_in_acc: assert property (@(posedge clk) disable iff (rst)
    acc_stat.done |-> (state == ST_ACC))
    else $error("accumulator finished outside accumulation");

endmodule
